[hw/rtl/tunnel_bringup_supervisor_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tunnel bring-up supervisor
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TUNNEL_BRINGUP_SUPERVISOR_CORE_ASSERT_SVH
`define TUNNEL_BRINGUP_SUPERVISOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define TBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tbs_pkg.sv]
// ----------------------------------------------------------------------------
// tbs_pkg
// Types and constants shared by the tunnel bring-up supervisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 32;
    localparam int CNT_BITS  = 4;
    localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

    localparam int IN_BYTES  = 5;
    localparam int OUT_BYTES = 2;
    localparam int IN_BITS   = IN_BYTES * 8;
    localparam int OUT_BITS  = OUT_BYTES * 8;

    localparam logic [CFG_BITS-1:0] RETRY_RESET   = 32'd15000;
    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 32'd20000;
    localparam logic [CNT_BITS-1:0] MAX_ATT_RESET = 4'd3;
    localparam logic [CNT_BITS-1:0] CNT_MAX       = 4'd15;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HS   = 2'd1,
        PH_UP   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OFF        = 2'd0,
        ST_FAILED     = 2'd1,
        ST_UP         = 2'd2,
        ST_CONNECTING = 2'd3
    } status_t;

    // start attempt outcome; anything else counts as fatal
    localparam logic [1:0] OUTCOME_BEGUN     = 2'd0;
    localparam logic [1:0] OUTCOME_TRANSIENT = 2'd1;

    typedef enum logic [1:0] {
        REG_RETRY_INTERVAL = 2'd0,
        REG_HS_TIMEOUT     = 2'd1,
        REG_MAX_ATTEMPTS   = 2'd2
    } cfg_reg_t;

    // packed: last member in the lowest bits
    typedef struct packed {
        logic        clock_ready;
        logic        peer_up;
        logic        link_just_connected;
        logic        link_connected;
        logic        settings_present;
        logic        tunnel_enabled;
        logic [31:0] now_ms;
    } in_fields_t;

    typedef struct packed {
        logic [1:0]  start_outcome;
        in_fields_t  f;
    } in_item_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] attempts_used;
        logic [1:0]          status;
        logic                route_switch;
        logic                teardown;
        logic                start_request;
        logic [1:0]          phase;
    } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/tunnel_bringup_supervisor_core.sv]
// ----------------------------------------------------------------------------
// Tunnel bring-up supervisor core
// Steps the tunnel bring-up state once per tick request.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one tick request: time, enable/settings/link/peer/clock flags
//   and the start outcome. m_* returns one result per tick: phase, start,
//   teardown and route-switch strobes, status and failed-attempt count.
//   cfg_* writes retry interval (0), handshake timeout (1), max attempts (2);
//   write only while no tick is in flight. cfg_ready is always high.
// Path: each request passes the input register, then the result register.
// Throughput: one request per cycle unless m_* stalls; the tick is an input
//   register, 32-bit subtract/compare steps, and the state and result registers.
// Stall: the result register holds while m_tready is low; one more request
//   sits in the input register, then s_tready drops until the result moves.
// Reset: state goes idle, counters and times clear, config takes its
//   defaults, both channels empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tunnel_bringup_supervisor_core_assert.svh"

module tunnel_bringup_supervisor_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // tdata: now_ms[31:0], tunnel_enabled, settings_present, link_connected,
    //        link_just_connected, peer_up, clock_ready, start_outcome[1:0]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tbs_pkg::IN_BITS-1:0]   s_tdata,
    // tdata: phase[1:0], start_request, teardown, route_switch, status[1:0],
    //        attempts_used[3:0], zero pad
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tbs_pkg::OUT_BITS-1:0]       m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [tbs_pkg::CFG_BITS-1:0]  cfg_data
);
    import tbs_pkg::*;

    // config
    logic [CFG_BITS-1:0] retry_reg;
    logic [CFG_BITS-1:0] timeout_reg;
    logic [CNT_BITS-1:0] max_att_reg;

    // input stage
    logic     in_valid_reg;
    in_item_t in_reg;

    // state
    phase_t              phase_reg, phase_next;
    logic                gave_up_reg, gave_up_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    time_t               last_reg, last_next;
    time_t               hs_start_reg, hs_start_next;

    // output stage
    logic      out_valid_reg;
    out_item_t out_reg, out_next;

    logic fire;
    logic out_free;

    // decode of the current tick
    time_t               now;
    logic                cleared;     // enable/settings dropped
    logic                link_down;
    logic                active;      // link branch taken
    phase_t              eff_phase;   // phase after a reconnect reset
    logic                base_gave;
    logic [CNT_BITS-1:0] base_cnt;
    time_t               base_last;
    logic [CNT_BITS-1:0] fail_cnt;
    logic                fail_gave;
    logic                hs_expired;
    logic                spaced;
    logic                peer_ok;
    logic                hs_fail;
    logic                up_lost;
    logic                attempt_go;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_BITS'(out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_reg   <= RETRY_RESET;
            timeout_reg <= TIMEOUT_RESET;
            max_att_reg <= MAX_ATT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RETRY_INTERVAL: retry_reg   <= cfg_data;
                REG_HS_TIMEOUT:     timeout_reg <= cfg_data;
                REG_MAX_ATTEMPTS:   max_att_reg <= cfg_data[CNT_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= in_item_t'(s_tdata);
    end

    // ---- decode ----
    assign now       = TIME_BITS'(in_reg.f.now_ms);
    assign cleared   = !in_reg.f.tunnel_enabled || !in_reg.f.settings_present;
    assign link_down = !cleared && !in_reg.f.link_connected;
    assign active    = !cleared && in_reg.f.link_connected;

    assign eff_phase = in_reg.f.link_just_connected ? PH_IDLE : phase_reg;
    assign base_gave = in_reg.f.link_just_connected ? 1'b0 : gave_up_reg;
    assign base_cnt  = in_reg.f.link_just_connected ? '0 : cnt_reg;
    assign base_last = in_reg.f.link_just_connected ? '0 : last_reg;

    assign fail_cnt  = (base_cnt < CNT_MAX) ? base_cnt + 1'b1 : base_cnt;
    assign fail_gave = base_gave || (fail_cnt >= max_att_reg);

    assign hs_expired = CMP_BITS'(time_t'(now - hs_start_reg)) > CMP_BITS'(timeout_reg);
    assign spaced     = (base_last == '0) ||
                        (CMP_BITS'(time_t'(now - base_last)) >= CMP_BITS'(retry_reg));

    assign peer_ok    = active && eff_phase == PH_HS && in_reg.f.peer_up;
    assign hs_fail    = active && eff_phase == PH_HS && !in_reg.f.peer_up && hs_expired;
    assign up_lost    = active && eff_phase == PH_UP && !in_reg.f.peer_up;
    assign attempt_go = active && eff_phase != PH_HS && eff_phase != PH_UP &&
                        !base_gave && spaced && in_reg.f.clock_ready;

    // ---- next state ----
    always_comb
    begin
        phase_next    = phase_reg;
        gave_up_next  = gave_up_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        hs_start_next = hs_start_reg;
        if (cleared)
        begin
            phase_next   = PH_IDLE;
            gave_up_next = 1'b0;
            cnt_next     = '0;
            last_next    = '0;
        end
        else if (link_down)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            phase_next   = eff_phase;
            gave_up_next = base_gave;
            cnt_next     = base_cnt;
            last_next    = base_last;
            case (eff_phase)
                PH_HS:
                begin
                    if (peer_ok)
                    begin
                        phase_next = PH_UP;
                        cnt_next   = '0;
                    end
                    else if (hs_fail)
                    begin
                        phase_next   = PH_IDLE;
                        last_next    = now;
                        cnt_next     = fail_cnt;
                        gave_up_next = fail_gave;
                    end
                end
                PH_UP:
                begin
                    if (up_lost)
                    begin
                        phase_next = PH_IDLE;
                        last_next  = now;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (attempt_go)
                    begin
                        last_next = now;
                        if (in_reg.start_outcome == OUTCOME_BEGUN)
                        begin
                            phase_next    = PH_HS;
                            hs_start_next = now;
                        end
                        else if (in_reg.start_outcome == OUTCOME_TRANSIENT)
                        begin
                            cnt_next     = fail_cnt;
                            gave_up_next = fail_gave;
                        end
                        else
                        begin
                            gave_up_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // ---- result ----
    always_comb
    begin
        out_next               = '0;
        out_next.phase         = phase_next;
        out_next.start_request = attempt_go;
        out_next.teardown      = ((cleared || link_down ||
                                   (active && in_reg.f.link_just_connected)) &&
                                  phase_reg != PH_IDLE) || hs_fail || up_lost;
        out_next.route_switch  = peer_ok;
        out_next.attempts_used = cnt_next;
        if (!in_reg.f.tunnel_enabled)
            out_next.status = ST_OFF;
        else if (gave_up_next)
            out_next.status = ST_FAILED;
        else if (phase_next == PH_UP)
            out_next.status = ST_UP;
        else
            out_next.status = ST_CONNECTING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            gave_up_reg   <= 1'b0;
            cnt_reg       <= '0;
            last_reg      <= '0;
            hs_start_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg    <= phase_next;
                gave_up_reg  <= gave_up_next;
                cnt_reg      <= cnt_next;
                last_reg     <= last_next;
                hs_start_reg <= hs_start_next;
            end
            if (out_free)
                out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= out_next;
    end

    // ---- checks ----
    `TBS_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg,
        "tick step did not produce a result")
    `TBS_ASSERT_NEXT(a_state_holds_idle, !fire,
        $stable(phase_reg) && $stable(cnt_reg) && $stable(gave_up_reg),
        "state changed without a tick")
    `TBS_ASSERT_NEXT(a_attempt_stamps_time, fire && attempt_go,
        last_reg == $past(now), "attempt did not record its time")
    `TBS_ASSERT_NOW(a_route_means_up, out_valid_reg && out_reg.route_switch,
        out_reg.phase == PH_UP && !out_reg.teardown, "route switch without up phase")

endmodule

`default_nettype wire
